@@ rtl/rmefs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package rmefs_pkg;

  localparam int HISTORY_DEPTH = 16;
  localparam int HIST_PTR_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HIST_CNT_W    = $clog2(HISTORY_DEPTH + 1);
  localparam int ENERGY_W      = 16;
  localparam int HIST_TOT_W    = ENERGY_W + $clog2(HISTORY_DEPTH + 1);
  localparam int DIM_W         = 12;
  localparam int DIFF_W        = 34;
  localparam int AREA_W        = 2 * DIM_W;
  localparam int DIV_N         = DIFF_W + 8;
  localparam int DIV_D         = AREA_W;
  localparam int DIV_CNT_W     = $clog2(DIV_N + 1);
  localparam int SCORE_W       = 17;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int GEO_W         = 16;
  localparam int SPACE_BELOW_MIN = 50;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd3;

  // divider operand selects
  localparam logic [1:0] DIV_MEAN   = 2'd0;
  localparam logic [1:0] DIV_SMOOTH = 2'd1;
  localparam logic [1:0] DIV_SCORE  = 2'd2;

  typedef struct packed {
    logic             ok;
    logic [DIM_W-1:0] left;
    logic [DIM_W-1:0] top;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } box_t;

  typedef struct packed {
    logic       load_item;
    logic       region_torso;
    logic       region_shoulder;
    logic       pixel_grey;
    logic       pixel_acc;
    logic       area_load;
    logic       div_start;
    logic [1:0] div_sel;
    logic       push;
    logic       smooth_load;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic in_op;
    logic box_ok;
    logic frame_end;
    logic div_busy;
    logic thr_zero;
    logic out_busy;
  } status_t;

  function automatic logic signed [GEO_W-1:0] smin(logic signed [GEO_W-1:0] a,
                                                   logic signed [GEO_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [GEO_W-1:0] smax(logic signed [GEO_W-1:0] a,
                                                   logic signed [GEO_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // Clamp a box to the frame; ok when it stays non-empty.
  function automatic box_t clamp_box(logic signed [GEO_W-1:0] x, logic signed [GEO_W-1:0] y,
                                     logic signed [GEO_W-1:0] w, logic signed [GEO_W-1:0] h,
                                     logic signed [GEO_W-1:0] fw, logic signed [GEO_W-1:0] fh);
    logic signed [GEO_W-1:0] cx, cy, cw, ch;
    box_t r;
    cx = smax('0, smin(x, fw - w));
    cy = smax('0, smin(y, fh - h));
    cw = smin(w, fw - cx);
    ch = smin(h, fh - cy);
    r.ok     = (cw > 0) && (ch > 0);
    r.left   = cx[DIM_W-1:0];
    r.top    = cy[DIM_W-1:0];
    r.width  = cw[DIM_W-1:0];
    r.height = ch[DIM_W-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/rmefs_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface rmefs_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [11:0] face_x;
  logic [11:0] face_y;
  logic [11:0] face_w;
  logic [11:0] face_h;
  logic [7:0]  curr_b;
  logic [7:0]  curr_g;
  logic [7:0]  curr_r;
  logic [7:0]  prev_b;
  logic [7:0]  prev_g;
  logic [7:0]  prev_r;

  modport source (output valid, op, face_x, face_y, face_w, face_h,
                  curr_b, curr_g, curr_r, prev_b, prev_g, prev_r, input ready);
  modport sink (input valid, op, face_x, face_y, face_w, face_h,
                curr_b, curr_g, curr_r, prev_b, prev_g, prev_r, output ready);
endinterface

interface rmefs_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] motion_score;
  logic [15:0] smoothed_energy;
  logic        region_valid;
  logic [11:0] region_left;
  logic [11:0] region_top;
  logic [11:0] region_width;
  logic [11:0] region_height;

  modport source (output valid, motion_score, smoothed_energy, region_valid,
                  region_left, region_top, region_width, region_height, input ready);
  modport sink (input valid, motion_score, smoothed_energy, region_valid,
                region_left, region_top, region_width, region_height, output ready);
endinterface
`default_nettype wire

@@ rtl/roi_motion_energy_fidget_score.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Frame-difference motion energy over a body region derived from a face box.
// A frame-start transaction (op 0) steps through capture, torso region and
// shoulder region; a pixel-pair transaction (op 1) steps through capture, grey
// conversion and accumulate. The last pixel of a frame with a valid region then
// runs three passes of one shared restoring divider at one quotient bit per
// cycle: each pass is a start state, 42 steps and a wait state that sees the
// divider idle; the passes give mean energy, moving average, and score, and the
// score pass is skipped when the threshold is zero. A frame end with no region
// goes to the output state. One result transaction is issued per frame end;
// it waits in an output register; the next frame end holds until it is taken.
module roi_motion_energy_fidget_score (
  input  wire logic                                clk,
  input  wire logic                                rst,
  rmefs_in_if.sink                                 pix_in,
  rmefs_out_if.source                              res_out,
  input  wire logic                                cfg_we,
  input  wire logic [rmefs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rmefs_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rmefs_pkg::*;

  cmd_t    cmd;
  status_t st;

  rmefs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pix_in.valid),
    .in_ready (pix_in.ready),
    .st       (st),
    .cmd      (cmd)
  );

  rmefs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .pix       (pix_in),
    .res       (res_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
`default_nettype wire

@@ rtl/rmefs_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rmefs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire rmefs_pkg::status_t st,
  output rmefs_pkg::cmd_t        cmd
);
  import rmefs_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_TORSO    = 4'd1;
  localparam logic [3:0] S_SHOULDER = 4'd2;
  localparam logic [3:0] S_GREY     = 4'd3;
  localparam logic [3:0] S_ACC      = 4'd4;
  localparam logic [3:0] S_AREA     = 4'd5;
  localparam logic [3:0] S_D1       = 4'd6;
  localparam logic [3:0] S_D1W      = 4'd7;
  localparam logic [3:0] S_PUSH     = 4'd8;
  localparam logic [3:0] S_D2       = 4'd9;
  localparam logic [3:0] S_D2W      = 4'd10;
  localparam logic [3:0] S_D3       = 4'd11;
  localparam logic [3:0] S_D3W      = 4'd12;
  localparam logic [3:0] S_OUT      = 4'd13;

  logic [3:0] state, state_next;

  // sequence one transaction through the datapath
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = st.in_op ? S_GREY : S_TORSO;
        end
      end
      S_TORSO: begin
        cmd.region_torso = 1'b1;
        state_next       = S_SHOULDER;
      end
      S_SHOULDER: begin
        cmd.region_shoulder = 1'b1;
        state_next          = S_IDLE;
      end
      S_GREY: begin
        cmd.pixel_grey = 1'b1;
        state_next     = S_ACC;
      end
      S_ACC: begin
        cmd.pixel_acc = 1'b1;
        if (!st.frame_end) state_next = S_IDLE;
        else if (st.box_ok) state_next = S_AREA;
        else state_next = S_OUT;
      end
      S_AREA: begin
        cmd.area_load = 1'b1;
        state_next    = S_D1;
      end
      S_D1: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_MEAN;
        state_next    = S_D1W;
      end
      S_D1W: if (!st.div_busy) state_next = S_PUSH;
      S_PUSH: begin
        cmd.push   = 1'b1;
        state_next = S_D2;
      end
      S_D2: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SMOOTH;
        state_next    = S_D2W;
      end
      S_D2W: if (!st.div_busy) state_next = S_D3;
      S_D3: begin
        cmd.smooth_load = 1'b1;
        cmd.div_start   = !st.thr_zero;
        cmd.div_sel     = DIV_SCORE;
        state_next      = st.thr_zero ? S_OUT : S_D3W;
      end
      S_D3W: if (!st.div_busy) state_next = S_OUT;
      S_OUT: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule
`default_nettype wire

@@ rtl/rmefs_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rmefs_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  rmefs_in_if.sink                                  pix,
  rmefs_out_if.source                               res,
  input  wire logic                                 cfg_we,
  input  wire logic [rmefs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rmefs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire rmefs_pkg::cmd_t                      cmd,
  output rmefs_pkg::status_t                        st
);
  import rmefs_pkg::*;

  // configuration
  logic [DIM_W-1:0] frame_width, frame_height;
  logic             color_mode;
  logic [15:0]      threshold;

  // captured item
  logic             it_op;
  logic [DIM_W-1:0] fx, fy, fw, fh;
  logic [7:0]       cb, cg, cr, pb, pg, pr;

  // scan and region
  logic [DIM_W-1:0] scan_column, scan_row;
  box_t             box;
  logic             torso_hit;
  logic [DIFF_W-1:0] diff_total;
  logic [7:0]       grey_c, grey_p;
  logic             in_box;

  // history
  logic [ENERGY_W-1:0]   hist_mem [HISTORY_DEPTH];
  logic [ENERGY_W-1:0]   hist_rd;
  logic [HIST_PTR_W-1:0] hist_ptr;
  logic [HIST_CNT_W-1:0] hist_cnt;
  logic [HIST_TOT_W-1:0] hist_tot;
  logic [AREA_W-1:0]     area;
  logic [ENERGY_W-1:0]   mean, smoothed;

  // divider
  logic [DIV_N-1:0]     dvd;
  logic [DIV_D-1:0]     dvs;
  logic [DIV_D-1:0]     rem;
  logic [DIV_D:0]       rem_sh;
  logic                 qbit;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 div_busy;
  logic [DIV_N-1:0]     op_n;
  logic [DIV_D-1:0]     op_d;

  // geometry
  logic signed [GEO_W-1:0] gx, gy, gw, gh, gfw, gfh, gcx, gcy, gtw, gsw;
  box_t torso, shoulder;
  logic torso_room;
  logic [DIM_W-1:0] last_col, last_row;
  logic [SCORE_W-1:0] score;

  assign gx  = GEO_W'(fx);
  assign gy  = GEO_W'(fy);
  assign gw  = GEO_W'(fw);
  assign gh  = GEO_W'(fh);
  assign gfw = GEO_W'(frame_width);
  assign gfh = GEO_W'(frame_height);
  assign gcx = gx + (gw >>> 1);
  assign gcy = gy + (gh >>> 1);
  assign gtw = (gw + (gw <<< 1)) >>> 1;
  assign gsw = gw + (gw <<< 1);
  assign torso_room = (gfh - (gy + gh)) > GEO_W'(SPACE_BELOW_MIN);
  assign torso    = clamp_box(gcx - (gtw >>> 1), gy + gh, gtw, gh <<< 1, gfw, gfh);
  assign shoulder = clamp_box(gcx - (gsw >>> 1), gcy, gsw, gh, gfw, gfh);

  assign last_col = (frame_width == '0) ? '0 : frame_width - 1'b1;
  assign last_row = (frame_height == '0) ? '0 : frame_height - 1'b1;

  // grey conversion
  function automatic logic [7:0] to_grey(logic mode, logic [7:0] b, logic [7:0] g,
                                         logic [7:0] r);
    logic [21:0] s;
    s = 22'd4899 * 22'(r) + 22'd9617 * 22'(g) + 22'd1868 * 22'(b) + 22'd8192;
    return mode ? s[21:14] : b;
  endfunction

  // divider operands; the score pass takes the smoothed value still in the quotient
  always_comb begin
    unique case (cmd.div_sel)
      DIV_MEAN: begin
        op_n = {diff_total, 8'd0};
        op_d = area;
      end
      DIV_SMOOTH: begin
        op_n = DIV_N'(hist_tot);
        op_d = DIV_D'(hist_cnt);
      end
      DIV_SCORE: begin
        op_n = DIV_N'({dvd[ENERGY_W-1:0], 16'd0});
        op_d = DIV_D'(threshold);
      end
      default: begin
        op_n = '0;
        op_d = '1;
      end
    endcase
  end

  assign rem_sh = {rem, dvd[DIV_N-1]};
  assign qbit   = rem_sh >= {1'b0, dvs};
  assign mean   = (dvd[DIV_N-1:ENERGY_W] != '0) ? '1 : dvd[ENERGY_W-1:0];
  assign score  = (!box.ok || threshold == '0 || dvd[DIV_N-1:16] != '0) ? '0
                : SCORE_W'(17'h10000 - SCORE_W'(dvd[15:0]));

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_W'(640);
      frame_height <= DIM_W'(480);
      color_mode   <= 1'b1;
      threshold    <= 16'd2560;
      scan_column  <= '0;
      scan_row     <= '0;
      box          <= '0;
      torso_hit    <= 1'b0;
      diff_total   <= '0;
      hist_ptr     <= '0;
      hist_cnt     <= '0;
      hist_tot     <= '0;
      div_busy     <= 1'b0;
      div_cnt      <= '0;
      res.valid    <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  frame_width  <= cfg_data[DIM_W-1:0];
          REG_FRAME_HEIGHT: frame_height <= cfg_data[DIM_W-1:0];
          REG_COLOR_MODE:   color_mode   <= cfg_data[0];
          REG_THRESHOLD:    threshold    <= cfg_data[15:0];
          default: ;
        endcase
      end

      // derive the body region
      if (cmd.region_torso) begin
        scan_column <= '0;
        scan_row    <= '0;
        diff_total  <= '0;
        if (fw == '0 || fh == '0) begin
          box       <= '0;
          torso_hit <= 1'b1;
        end else if (torso_room && torso.ok) begin
          box       <= torso;
          torso_hit <= 1'b1;
        end else begin
          torso_hit <= 1'b0;
        end
      end
      if (cmd.region_shoulder && !torso_hit) begin
        box <= shoulder.ok ? shoulder : '0;
      end

      // accumulate and advance the scan
      if (cmd.pixel_acc) begin
        if (in_box) diff_total <= diff_total + DIFF_W'(grey_c > grey_p ? grey_c - grey_p
                                                                      : grey_p - grey_c);
        if (scan_column < last_col) begin
          scan_column <= scan_column + 1'b1;
        end else begin
          scan_column <= '0;
          scan_row    <= (scan_row < last_row) ? scan_row + 1'b1 : '0;
        end
      end

      // push the frame mean into the history
      if (cmd.push) begin
        if (hist_cnt < HIST_CNT_W'(HISTORY_DEPTH)) begin
          hist_cnt <= hist_cnt + 1'b1;
          hist_tot <= hist_tot + HIST_TOT_W'(mean);
        end else begin
          hist_tot <= hist_tot - HIST_TOT_W'(hist_rd) + HIST_TOT_W'(mean);
        end
        hist_ptr <= (hist_ptr == HIST_PTR_W'(HISTORY_DEPTH - 1)) ? '0 : hist_ptr + 1'b1;
      end

      // divider control
      if (cmd.div_start) begin
        div_busy <= 1'b1;
        div_cnt  <= DIV_CNT_W'(DIV_N);
      end else if (div_busy) begin
        div_cnt <= div_cnt - 1'b1;
        if (div_cnt == DIV_CNT_W'(1)) div_busy <= 1'b0;
      end

      // output register
      if (cmd.out_load) begin
        res.valid  <= 1'b1;
        diff_total <= '0;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      it_op <= pix.op;
      fx <= pix.face_x;
      fy <= pix.face_y;
      fw <= pix.face_w;
      fh <= pix.face_h;
      cb <= pix.curr_b;
      cg <= pix.curr_g;
      cr <= pix.curr_r;
      pb <= pix.prev_b;
      pg <= pix.prev_g;
      pr <= pix.prev_r;
    end
    if (cmd.pixel_grey) begin
      grey_c <= to_grey(color_mode, cb, cg, cr);
      grey_p <= to_grey(color_mode, pb, pg, pr);
      in_box <= it_op && box.ok && scan_column >= box.left
                && {1'b0, scan_column} < {1'b0, box.left} + {1'b0, box.width}
                && scan_row >= box.top
                && {1'b0, scan_row} < {1'b0, box.top} + {1'b0, box.height};
    end
    if (cmd.area_load) begin
      area    <= box.width * box.height;
      hist_rd <= hist_mem[hist_ptr];
    end
    if (cmd.push) hist_mem[hist_ptr] <= mean;
    if (cmd.smooth_load) smoothed <= dvd[ENERGY_W-1:0];
    if (cmd.div_start) begin
      dvd <= op_n;
      dvs <= op_d;
      rem <= '0;
    end else if (div_busy) begin
      dvd <= {dvd[DIV_N-2:0], qbit};
      rem <= DIV_D'(qbit ? rem_sh - {1'b0, dvs} : rem_sh);
    end
    if (cmd.out_load) begin
      res.motion_score    <= score;
      res.smoothed_energy <= box.ok ? smoothed : '0;
      res.region_valid    <= box.ok;
      res.region_left     <= box.left;
      res.region_top      <= box.top;
      res.region_width    <= box.width;
      res.region_height   <= box.height;
    end
  end

  always_comb begin
    st.in_op     = pix.op;
    st.box_ok    = box.ok;
    st.frame_end = (scan_column >= last_col) && (scan_row >= last_row);
    st.div_busy  = div_busy;
    st.thr_zero  = (threshold == '0);
    st.out_busy  = res.valid && !res.ready;
  end

endmodule
`default_nettype wire
